@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the string unescaper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define JSU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/jsu_pkg.sv @@
// Types, codes and decode functions of the JSON string unescaper.
package jsu_pkg;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISS_QUOTE = 3'd1;
    localparam logic [2:0] ST_BAD_ESC    = 3'd2;
    localparam logic [2:0] ST_BAD_HEX    = 3'd3;
    localparam logic [2:0] ST_BAD_SURR   = 3'd4;
    localparam logic [2:0] ST_CTRL       = 3'd5;

    // Decode modes
    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_HEX1    = 3'd2;
    localparam logic [2:0] MODE_SURR_BS = 3'd3;
    localparam logic [2:0] MODE_SURR_U  = 3'd4;
    localparam logic [2:0] MODE_HEX2    = 3'd5;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;

    // Entries held between front and back
    localparam int QUEUE_DEPTH = 4;

    // One decoded request: up to four bytes, or one byteless result when cnt is 0.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      cnt;
        logic            done;
        logic [2:0]      status;
    } jsu_entry_t;

    // Hex digit value, bit 4 flags a valid digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // UTF-8 encoding of a code point up to 21 bits.
    function automatic jsu_entry_t encode_utf8(input logic [20:0] u);
        jsu_entry_t e;
        e = '0;
        if (u[20:7] == 14'd0) begin
            e.bytes[0] = u[7:0];
            e.cnt      = 3'd1;
        end else if (u[20:11] == 10'd0) begin
            e.bytes[0] = {3'b110, u[10:6]};
            e.bytes[1] = {2'b10, u[5:0]};
            e.cnt      = 3'd2;
        end else if (u[20:16] == 5'd0) begin
            e.bytes[0] = {4'b1110, u[15:12]};
            e.bytes[1] = {2'b10, u[11:6]};
            e.bytes[2] = {2'b10, u[5:0]};
            e.cnt      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, u[20:18]};
            e.bytes[1] = {2'b10, u[17:12]};
            e.bytes[2] = {2'b10, u[11:6]};
            e.bytes[3] = {2'b10, u[5:0]};
            e.cnt      = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ hw/rtl/jsu_front.sv @@
// Front end: takes raw bytes, runs the escape state machine, builds decoded requests.
module jsu_front
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       q_full,
    output logic       q_push,
    output jsu_entry_t q_entry
);
`include "assert_macros.svh"

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  hs_reg, hs_next;
    logic [11:0] acc_reg, acc_next;
    logic [4:0]  hv;
    logic [15:0] code;
    logic [20:0] pair_cp;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign hv      = hex_value(s_in_byte);
    assign code    = {acc_reg, hv[3:0]};
    assign pair_cp = {1'b0, hs_reg, code[9:0]} + 21'h10000;

    // Escape decoding
    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        hs_next   = hs_reg;
        acc_next  = acc_reg;
        q_entry   = '0;
        case (mode_reg)
            MODE_NORMAL: begin
                if (s_in_byte == CH_QUOTE) begin
                    q_entry.done = 1'b1;
                end else if (s_in_byte == 8'd0) begin
                    q_entry.status = ST_MISS_QUOTE;
                end else if (s_in_byte == CH_BSLASH) begin
                    mode_next = MODE_ESC;
                end else if (s_in_byte < 8'h20) begin
                    q_entry.status = ST_CTRL;
                end else begin
                    q_entry.bytes[0] = s_in_byte;
                    q_entry.cnt      = 3'd1;
                end
            end
            MODE_ESC: begin
                mode_next   = MODE_NORMAL;
                q_entry.cnt = 3'd1;
                case (s_in_byte)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: q_entry.bytes[0] = s_in_byte;
                    CH_B: q_entry.bytes[0] = 8'h08;
                    CH_F: q_entry.bytes[0] = 8'h0c;
                    CH_N: q_entry.bytes[0] = 8'h0a;
                    CH_T: q_entry.bytes[0] = 8'h09;
                    CH_R: q_entry.bytes[0] = 8'h0d;
                    CH_U: begin
                        mode_next   = MODE_HEX1;
                        cnt_next    = 2'd0;
                        q_entry.cnt = 3'd0;
                    end
                    default: begin
                        q_entry.cnt    = 3'd0;
                        q_entry.status = ST_BAD_ESC;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hv[4]) begin
                    mode_next      = MODE_NORMAL;
                    cnt_next       = 2'd0;
                    q_entry.status = ST_BAD_HEX;
                end else if (cnt_reg != 2'd3) begin
                    acc_next = code[11:0];
                    cnt_next = cnt_reg + 2'd1;
                end else begin
                    cnt_next  = 2'd0;
                    mode_next = MODE_NORMAL;
                    if (mode_reg == MODE_HEX1) begin
                        if (code[15:10] == 6'b110110) begin
                            // high surrogate, wait for the low half
                            hs_next   = code[9:0];
                            mode_next = MODE_SURR_BS;
                        end else begin
                            q_entry = encode_utf8({5'd0, code});
                        end
                    end else if (code[15:10] != 6'b110111) begin
                        q_entry.status = ST_BAD_SURR;
                    end else begin
                        q_entry = encode_utf8(pair_cp);
                    end
                end
            end
            MODE_SURR_BS: begin
                if (s_in_byte == CH_BSLASH) begin
                    mode_next = MODE_SURR_U;
                end else begin
                    mode_next      = MODE_NORMAL;
                    q_entry.status = ST_BAD_SURR;
                end
            end
            MODE_SURR_U: begin
                if (s_in_byte == CH_U) begin
                    mode_next = MODE_HEX2;
                    cnt_next  = 2'd0;
                end else begin
                    mode_next      = MODE_NORMAL;
                    q_entry.status = ST_BAD_SURR;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                cnt_next  = 2'd0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
        end else if (q_push) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Code unit payload
    always_ff @(posedge aclk) begin
        if (q_push) begin
            hs_reg  <= hs_next;
            acc_reg <= acc_next;
        end
    end

    `JSU_ASSERT_NEXT(a_start_after_end, aclk, aresetn,
        q_push && (q_entry.done || q_entry.status != ST_OK),
        mode_reg == MODE_NORMAL && cnt_reg == 2'd0, "end of string did not return to start")
    `JSU_ASSERT(a_byteless_flags, aclk, aresetn,
        q_push && q_entry.cnt != 3'd0 |-> !q_entry.done && q_entry.status == ST_OK,
        "byte request carries end flags")

endmodule

@@ hw/rtl/jsu_queue.sv @@
// Short register queue of decoded requests between front and back.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  jsu_entry_t push_entry,
    input  logic       pop,
    output jsu_entry_t head,
    output logic       empty,
    output logic       full
);
`include "assert_macros.svh"

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    jsu_entry_t            mem_reg [DEPTH];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       count_reg, count_next;

    assign empty = (count_reg == CntW'(0));
    assign full  = (count_reg == CntW'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `JSU_ASSERT(a_no_overflow, aclk, aresetn, push |-> !full || pop, "push into full queue")
    `JSU_ASSERT(a_no_underflow, aclk, aresetn, pop |-> !empty, "pop from empty queue")

endmodule

@@ hw/rtl/jsu_back.sv @@
// Back end: walks the bytes of each queued request and presents one result per cycle while m_ready is high.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  jsu_entry_t head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_run_last,
    output logic       m_string_done,
    output logic [2:0] m_status
);
`include "assert_macros.svh"

    logic [1:0] k_reg, k_next;
    logic       take;

    assign m_valid       = !empty;
    assign m_has_byte    = (head.cnt != 3'd0);
    assign m_out_byte    = m_has_byte ? head.bytes[k_reg] : 8'd0;
    assign m_run_last    = !m_has_byte || ({1'b0, k_reg} == head.cnt - 3'd1);
    assign m_string_done = head.done;
    assign m_status      = head.status;

    assign take = m_valid && m_ready;
    assign pop  = take && m_run_last;

    // Byte index within the current request
    always_comb begin
        k_next = k_reg;
        if (pop) begin
            k_next = 2'd0;
        end else if (take) begin
            k_next = k_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 2'd0;
        end else begin
            k_reg <= k_next;
        end
    end

    `JSU_ASSERT(a_idx_in_range, aclk, aresetn,
        !empty && head.cnt != 3'd0 |-> 3'(k_reg) < head.cnt, "byte index past request")
    `JSU_ASSERT(a_idx_zero_byteless, aclk, aresetn,
        !empty && head.cnt == 3'd0 |-> k_reg == 2'd0, "byteless request with nonzero index")

endmodule

@@ hw/rtl/json_string_unescape_utf8.sv @@
// Each accepted input byte is stored as a request in the register queue; results are offered from its head.
// Throughput: one input byte per cycle while the request queue has room;
// results leave at one per cycle while m_ready is high, a code point expands to up to 4 results.
// The queue depth (QDEPTH entries) sets how long output stalls can be absorbed.
// Reset: synchronous active-low aresetn returns to normal mode with an empty queue.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic       m_run_last,
    output logic       m_string_done,
    output logic [2:0] m_status
);

    jsu_entry_t push_entry;
    jsu_entry_t head;
    logic       push;
    logic       pop;
    logic       empty;
    logic       full;

    jsu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    jsu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    jsu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_has_byte    (m_has_byte),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done),
        .m_status      (m_status)
    );

endmodule

@@ verif/json_string_unescape_utf8_test.sv @@
// Self-checking testbench for the JSON string unescaper with UTF-8 output.
module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    localparam int RANDOM_ITEMS = 240;
    localparam int STUCK_LIMIT  = 2000;
    localparam int LONG_HOLD    = 64;
    localparam int CALM_TAIL    = 40;
    localparam int END_WAIT     = 8;

    // One decoded result as seen on the m_ side
    typedef struct {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
        logic [2:0] status;
    } decoded_t;

    // Raw string byte, or a marker that holds the sender until all output drains
    typedef struct {
        logic [7:0] data;
        bit         drain;
    } raw_item_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_has_byte;
    logic       m_run_last;
    logic       m_string_done;
    logic [2:0] m_status;

    raw_item_t raw_q[$];
    decoded_t  expected_q[$];
    int        error_count  = 0;
    int        fed_count    = 0;
    int        results_seen = 0;
    int        stuck_cycles = 0;

    // Sender and receiver pacing
    int        send_gap  = 0;
    int        recv_gap  = 0;
    int        hold_left = 0;
    bit        long_hold_done = 1'b0;
    logic      next_valid;
    logic [7:0] next_data;
    logic      next_ready;
    raw_item_t head_item;
    decoded_t  exp_res;

    // Decoder state of the predictor
    logic [2:0]  dec_mode  = MODE_NORMAL;
    logic [1:0]  digit_cnt = 2'd0;
    logic [15:0] high_unit = 16'h0000;
    logic [15:0] code_acc  = 16'h0000;

    json_string_unescape_utf8 dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_has_byte    (m_has_byte),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done),
        .m_status      (m_status)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Bit 4 set when c is a hex digit, low nibble holds its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic void push_result(input logic [7:0] ob, input logic hb,
                                        input logic last, input logic done,
                                        input logic [2:0] st);
        decoded_t r;
        r.out_byte    = ob;
        r.has_byte    = hb;
        r.run_last    = last;
        r.string_done = done;
        r.status      = st;
        expected_q.insert(expected_q.size(), r);
    endfunction

    function automatic void restart_decoder();
        dec_mode  = MODE_NORMAL;
        digit_cnt = 2'd0;
        high_unit = 16'h0000;
        code_acc  = 16'h0000;
    endfunction

    function automatic void reject(input logic [2:0] st);
        restart_decoder();
        push_result(8'h00, 1'b0, 1'b1, 1'b0, st);
    endfunction

    // Byteless ok result for a request that only advances the decoder
    function automatic void push_step();
        push_result(8'h00, 1'b0, 1'b1, 1'b0, ST_OK);
    endfunction

    // UTF-8 bytes of one code point, last one flagged
    function automatic void emit_code_point(input logic [20:0] u);
        logic [7:0] b[4];
        int n;
        if (u < 21'h80) begin
            b[0] = u[7:0];
            n = 1;
        end else if (u < 21'h800) begin
            b[0] = 8'hc0 | 8'(u[10:6]);
            b[1] = 8'h80 | 8'(u[5:0]);
            n = 2;
        end else if (u < 21'h10000) begin
            b[0] = 8'he0 | 8'(u[15:12]);
            b[1] = 8'h80 | 8'(u[11:6]);
            b[2] = 8'h80 | 8'(u[5:0]);
            n = 3;
        end else begin
            b[0] = 8'hf0 | 8'(u[20:18]);
            b[1] = 8'h80 | 8'(u[17:12]);
            b[2] = 8'h80 | 8'(u[11:6]);
            b[3] = 8'h80 | 8'(u[5:0]);
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            push_result(b[k], 1'b1, k == n - 1, 1'b0, ST_OK);
        end
    endfunction

    // Expected results of one accepted string byte
    function automatic void decode_byte(input logic [7:0] c);
        logic [4:0]  dig;
        logic [20:0] cp;
        logic [7:0]  esc;
        logic        esc_ok;
        case (dec_mode)
            MODE_NORMAL: begin
                if (c == CH_QUOTE) begin
                    restart_decoder();
                    push_result(8'h00, 1'b0, 1'b1, 1'b1, ST_OK);
                end else if (c == 8'h00) begin
                    reject(ST_MISS_QUOTE);
                end else if (c == CH_BSLASH) begin
                    dec_mode = MODE_ESC;
                    push_step();
                end else if (c < 8'h20) begin
                    reject(ST_CTRL);
                end else begin
                    push_result(c, 1'b1, 1'b1, 1'b0, ST_OK);
                end
            end
            MODE_ESC: begin
                esc    = c;
                esc_ok = 1'b1;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
                    CH_B: esc = 8'h08;
                    CH_F: esc = 8'h0c;
                    CH_N: esc = 8'h0a;
                    CH_T: esc = 8'h09;
                    CH_R: esc = 8'h0d;
                    default: esc_ok = 1'b0;
                endcase
                if (c == CH_U) begin
                    dec_mode  = MODE_HEX1;
                    digit_cnt = 2'd0;
                    code_acc  = 16'h0000;
                    push_step();
                end else if (esc_ok) begin
                    dec_mode = MODE_NORMAL;
                    push_result(esc, 1'b1, 1'b1, 1'b0, ST_OK);
                end else begin
                    reject(ST_BAD_ESC);
                end
            end
            MODE_HEX1, MODE_HEX2: begin
                dig = hex_digit(c);
                if (!dig[4]) begin
                    reject(ST_BAD_HEX);
                end else begin
                    code_acc = {code_acc[11:0], dig[3:0]};
                    if (digit_cnt != 2'd3) begin
                        digit_cnt = digit_cnt + 2'd1;
                        push_step();
                    end else if (dec_mode == MODE_HEX1) begin
                        digit_cnt = 2'd0;
                        if (code_acc >= 16'hd800 && code_acc <= 16'hdbff) begin
                            // high surrogate: wait for the second code unit
                            high_unit = code_acc;
                            code_acc  = 16'h0000;
                            dec_mode  = MODE_SURR_BS;
                            push_step();
                        end else begin
                            cp = 21'(code_acc);
                            restart_decoder();
                            emit_code_point(cp);
                        end
                    end else if (code_acc < 16'hdc00 || code_acc > 16'hdfff) begin
                        reject(ST_BAD_SURR);
                    end else begin
                        cp = (((21'(high_unit) - 21'hd800) << 10)
                              | (21'(code_acc) - 21'hdc00)) + 21'h10000;
                        restart_decoder();
                        emit_code_point(cp);
                    end
                end
            end
            MODE_SURR_BS: begin
                if (c != CH_BSLASH) begin
                    reject(ST_BAD_SURR);
                end else begin
                    dec_mode = MODE_SURR_U;
                    push_step();
                end
            end
            MODE_SURR_U: begin
                if (c != CH_U) begin
                    reject(ST_BAD_SURR);
                end else begin
                    dec_mode  = MODE_HEX2;
                    digit_cnt = 2'd0;
                    code_acc  = 16'h0000;
                    push_step();
                end
            end
            default: begin
                restart_decoder();
                push_step();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] b);
        raw_item_t it;
        it.data  = b;
        it.drain = 1'b0;
        raw_q.insert(raw_q.size(), it);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + 8'(n);
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Backslash, u and four hex digits of mixed case
    function automatic void add_code_unit(input logic [15:0] u);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int i = 3; i >= 0; i--) begin
            add_byte(hex_char(u[4*i +: 4]));
        end
    endfunction

    function automatic logic [7:0] random_plain();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(8'h20, 8'hff));
        end while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] escape_char(input int idx);
        case (idx)
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return CH_SLASH;
            3: return CH_B;
            4: return CH_F;
            5: return CH_N;
            6: return CH_T;
            default: return CH_R;
        endcase
    endfunction

    function automatic logic [15:0] random_high_unit();
        return 16'($urandom_range(16'hd800, 16'hdbff));
    endfunction

    // Code unit outside the high surrogates, spread over 1-, 2- and 3-byte forms
    function automatic logic [15:0] random_bmp_unit();
        logic [15:0] u;
        case ($urandom_range(0, 3))
            0: u = 16'($urandom_range(0, 16'h7f));
            1: u = 16'($urandom_range(16'h80, 16'h7ff));
            2: begin
                do begin
                    u = 16'($urandom_range(16'h800, 16'hffff));
                end while (u >= 16'hd800 && u <= 16'hdbff);
            end
            default: u = 16'($urandom_range(16'hdc00, 16'hdfff)); // lone low surrogate
        endcase
        return u;
    endfunction

    // String that ends in an error instead of the closing quote
    function automatic void add_broken_tail();
        logic [7:0]  b;
        logic [15:0] u;
        case ($urandom_range(0, 6))
            0: add_byte(8'($urandom_range(1, 8'h1f)));
            1: add_byte(8'h00);
            2: begin
                add_byte(CH_BSLASH);
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F,
                                     CH_N, CH_T, CH_R, CH_U});
                add_byte(b);
            end
            3: begin
                if ($urandom_range(0, 1)) begin
                    add_code_unit(random_high_unit());
                end
                add_byte(CH_BSLASH);
                add_byte(CH_U);
                repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (hex_digit(b) & 5'h10);
                add_byte(b);
            end
            4: begin
                add_code_unit(random_high_unit());
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (b == CH_BSLASH);
                add_byte(b);
            end
            5: begin
                add_code_unit(random_high_unit());
                add_byte(CH_BSLASH);
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (b == CH_U);
                add_byte(b);
            end
            default: begin
                add_code_unit(random_high_unit());
                do begin
                    u = 16'($urandom_range(0, 16'hffff));
                end while (u >= 16'hdc00 && u <= 16'hdfff);
                add_code_unit(u);
            end
        endcase
    endfunction

    // Mostly well-formed string bodies with random content
    function automatic void add_random_string();
        int pick;
        repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                add_byte(random_plain());
            end else if (pick < 55) begin
                add_byte(CH_BSLASH);
                add_byte(escape_char($urandom_range(0, 7)));
            end else if (pick < 80) begin
                add_code_unit(random_bmp_unit());
            end else begin
                add_code_unit(random_high_unit());
                add_code_unit(16'($urandom_range(16'hdc00, 16'hdfff)));
            end
        end
        if ($urandom_range(0, 99) < 80) begin
            add_byte(CH_QUOTE);
        end else begin
            add_broken_tail();
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, predicts each accepted request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte);
            end
            // hold the current request until it is taken
            if (!(s_valid && !s_ready)) begin
                next_valid = 1'b0;
                next_data  = s_in_byte;
                // drain marker: pause until every expected result has come
                if (raw_q.size() > 0 && raw_q[0].drain && expected_q.size() == 0) begin
                    void'(raw_q.pop_front());
                end
                if (send_gap == 0 && raw_q.size() > CALM_TAIL && (fed_count % 100) < 70
                    && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 3);
                end
                if (send_gap > 0) begin
                    send_gap--;
                end else if (raw_q.size() > 0 && !raw_q[0].drain) begin
                    head_item  = raw_q.pop_front();
                    next_data  = head_item.data;
                    next_valid = 1'b1;
                    fed_count++;
                end
                s_valid   <= next_valid;
                s_in_byte <= next_data;
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks accepted results and paces m_ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request pending: out_byte %0h status %0d",
                           m_out_byte, m_status);
                    error_count++;
                end else begin
                    exp_res = expected_q.pop_front();
                    check_field("out_byte", exp_res.out_byte, m_out_byte);
                    check_field("has_byte", exp_res.has_byte, m_has_byte);
                    check_field("run_last", exp_res.run_last, m_run_last);
                    check_field("string_done", exp_res.string_done, m_string_done);
                    check_field("status", exp_res.status, m_status);
                end
                results_seen++;
            end
            next_ready = 1'b1;
            // one long back-pressure stretch while input is still flowing
            if (!long_hold_done && results_seen >= 60 && raw_q.size() > 60) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                if (recv_gap == 0 && raw_q.size() > CALM_TAIL && (results_seen % 90) < 60
                    && $urandom_range(0, 4) == 0) begin
                    recv_gap = $urandom_range(1, 3);
                end
                if (recv_gap > 0) begin
                    recv_gap--;
                    next_ready = 1'b0;
                end
            end
            m_ready <= next_ready;
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready))) begin
            stuck_cycles++;
        end else begin
            stuck_cycles = 0;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : run_ctrl
        raw_item_t marker;
        int        total;
        bit        drain_added;
        marker.data  = 8'h00;
        marker.drain = 1'b1;
        drain_added  = 1'b0;

        // Directed opening: byte extremes, an escape, \u0000, a surrogate pair, errors
        add_byte(8'hff);
        add_byte(8'h20);
        add_byte(CH_BSLASH);
        add_byte(CH_N);
        add_code_unit(16'h0000);
        add_code_unit(16'hd83d);
        add_code_unit(16'hde00);
        add_byte(8'h1f);            // control char
        add_byte(8'h00);            // missing closing quote
        add_byte(CH_BSLASH);
        add_byte(8'h78);            // unknown escape letter
        add_byte(CH_QUOTE);         // empty string

        total = raw_q.size() + RANDOM_ITEMS;
        while (raw_q.size() < total) begin
            add_random_string();
            if (!drain_added && raw_q.size() > 150) begin
                raw_q.insert(raw_q.size(), marker);
                drain_added = 1'b1;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (raw_q.size() != 0 || s_valid || expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (END_WAIT) @(posedge aclk);

        if (error_count == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
